// ===== rtl/core/pvs_pkg.sv =====
package pvs_pkg;

   // Port widths
   localparam int unsigned CSR_W    = 11;
   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned VERTEX_W = 10;
   localparam int unsigned COUNT_W  = 11;

   // Defaults
   localparam int unsigned MAX_VERTICES_DEFAULT = 1024;
   localparam logic [CSR_W-1:0] VCOUNT_RESET    = CSR_W'(1024);

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_FREE_TO_SOL     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE_TO_NONFREE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SOL_TO_FREE     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONFREE_TO_FREE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_TO_REMOVED      = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR           = 3'd5;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      MV_FREE_TO_SOL,
      MV_FREE_TO_NONFREE,
      MV_SOL_TO_FREE,
      MV_NONFREE_TO_FREE,
      MV_TO_REMOVED,
      MV_CLEAR,
      MV_REFUSE
   } move_type;

   typedef struct packed {
      move_type              kind;
      logic                  side;
      logic [VERTEX_W-1:0]   vertex;
   } item_type;

   typedef struct packed {
      logic               refused;
      logic [COUNT_W-1:0] solution_count_a;
      logic [COUNT_W-1:0] solution_count_b;
      logic [COUNT_W-1:0] free_count_a;
      logic [COUNT_W-1:0] free_count_b;
      logic [COUNT_W-1:0] removed_count_a;
      logic [COUNT_W-1:0] removed_count_b;
      logic               maximal_a;
      logic               maximal_b;
      logic               sizes_equal;
   } result_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_SWEEP,
      BK_IDLE,
      BK_CHECK,
      BK_SWAP1,
      BK_SWAP2,
      BK_RESULT
   } back_state_type;

endpackage

// ===== rtl/core/pvs_front.sv =====
module pvs_front #(
   parameter int unsigned MAX_VERTICES = pvs_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [pvs_pkg::FUNC_W-1:0]              req_func,
   input  logic                                    req_side,
   input  logic [pvs_pkg::VERTEX_W-1:0]            req_vertex,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]       eff_count,
   input  logic                                    busy,
   input  logic                                    q_full,
   output logic                                    push,
   output pvs_pkg::item_type                       push_item
);
   import pvs_pkg::*;

   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned RW = (CW > VERTEX_W) ? CW : VERTEX_W;

   logic     in_range;
   move_type kind;

   // Refuse vertices beyond the active count
   assign in_range = RW'(req_vertex) < RW'(eff_count);

   // Classify the request
   always_comb begin
      kind = MV_REFUSE;
      unique case (req_func)
         FUNC_FREE_TO_SOL:     kind = in_range ? MV_FREE_TO_SOL     : MV_REFUSE;
         FUNC_FREE_TO_NONFREE: kind = in_range ? MV_FREE_TO_NONFREE : MV_REFUSE;
         FUNC_SOL_TO_FREE:     kind = in_range ? MV_SOL_TO_FREE     : MV_REFUSE;
         FUNC_NONFREE_TO_FREE: kind = in_range ? MV_NONFREE_TO_FREE : MV_REFUSE;
         FUNC_TO_REMOVED:      kind = in_range ? MV_TO_REMOVED      : MV_REFUSE;
         FUNC_CLEAR:           kind = MV_CLEAR;
         default:              kind = MV_REFUSE;
      endcase
   end

   // Accept while the queue has room and no clearing pass runs
   assign req_ready        = !q_full && !busy;
   assign push             = req_valid && req_ready;
   assign push_item.kind   = kind;
   assign push_item.side   = req_side;
   assign push_item.vertex = req_vertex;

endmodule

// ===== rtl/core/pvs_fifo.sv =====
module pvs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pvs_pkg::item_type push_item,
   input  logic              pop,
   output pvs_pkg::item_type head,
   output logic              not_empty,
   output logic              full
);
   import pvs_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   fill_ff, fill_in;

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == NW'(QUEUE_DEPTH));

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/pvs_back.sv =====
module pvs_back #(
   parameter int unsigned MAX_VERTICES = pvs_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear_req,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] eff_count,
   input  logic                              q_valid,
   input  pvs_pkg::item_type                 q_item,
   output logic                              q_pop,
   output logic                              busy,
   output logic                              res_valid,
   output pvs_pkg::result_type               res,
   input  logic                              res_ready
);
   import pvs_pkg::*;

   localparam int unsigned IW = $clog2(MAX_VERTICES);
   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned XW = CW + 1;
   localparam int unsigned VW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int unsigned UW = (IW > VERTEX_W) ? IW : VERTEX_W;

   // Position and inverse tables per side
   logic [IW-1:0] order_a_mem [MAX_VERTICES];
   logic [IW-1:0] order_b_mem [MAX_VERTICES];
   logic [IW-1:0] place_a_mem [MAX_VERTICES];
   logic [IW-1:0] place_b_mem [MAX_VERTICES];

   logic [IW-1:0] ord_rd_a_ff, ord_rd_b_ff, plc_rd_a_ff, plc_rd_b_ff;
   logic [1:0]    ord_we, plc_we;
   logic [IW-1:0] ord_wa, ord_wd, plc_wa, plc_wd;
   logic [IW-1:0] ord_ra, plc_ra;

   back_state_type state_ff, state_in;
   logic [IW-1:0]  sweep_idx_ff, sweep_idx_in;
   logic           for_item_ff, for_item_in;
   move_type       kind_ff, kind_in;
   logic           side_ff, side_in;
   logic [IW-1:0]  u_ff, u_in;
   logic [CW-1:0]  sol_sel_ff, sol_sel_in;
   logic [XW-1:0]  fend_ff, fend_in;
   logic [CW-1:0]  rbeg_ff, rbeg_in;
   logic [IW-1:0]  p_ff, p_in;
   logic [IW-1:0]  q_ff, q_in;
   logic           refused_ff, refused_in;

   logic [CW-1:0]  sol_ff [2], sol_in [2];
   logic [CW-1:0]  fre_ff [2], fre_in [2];
   logic [CW-1:0]  gone_ff [2], gone_in [2];

   logic [UW-1:0]  head_wide;
   logic [IW-1:0]  head_idx;
   logic [CW-1:0]  sol_h, fre_h, gone_h;
   logic [IW-1:0]  p_cur, other;
   logic [XW-1:0]  p_x, sol_x, rbeg_x, q_x;
   logic           move_ok;

   function automatic logic [COUNT_W-1:0] to_out(input logic [CW-1:0] c);
      logic [VW-1:0] w;
      w = VW'(c);
      return w[COUNT_W-1:0];
   endfunction

   assign head_wide = UW'(q_item.vertex);
   assign head_idx  = head_wide[IW-1:0];
   assign sol_h     = q_item.side ? sol_ff[1]  : sol_ff[0];
   assign fre_h     = q_item.side ? fre_ff[1]  : fre_ff[0];
   assign gone_h    = q_item.side ? gone_ff[1] : gone_ff[0];
   assign p_cur     = side_ff ? plc_rd_b_ff : plc_rd_a_ff;
   assign other     = side_ff ? ord_rd_b_ff : ord_rd_a_ff;

   // Check the source region and pick the boundary slot
   always_comb begin
      p_x     = XW'(p_cur);
      sol_x   = XW'(sol_sel_ff);
      rbeg_x  = XW'(rbeg_ff);
      move_ok = 1'b0;
      q_x     = '0;
      unique case (kind_ff)
         MV_FREE_TO_SOL: begin
            move_ok = (p_x >= sol_x) && (p_x < fend_ff);
            q_x     = sol_x;
         end
         MV_FREE_TO_NONFREE: begin
            move_ok = (p_x >= sol_x) && (p_x < fend_ff);
            q_x     = fend_ff - XW'(1);
         end
         MV_SOL_TO_FREE: begin
            move_ok = (p_x < sol_x);
            q_x     = sol_x - XW'(1);
         end
         MV_NONFREE_TO_FREE: begin
            move_ok = (p_x >= fend_ff) && (p_x < rbeg_x);
            q_x     = fend_ff;
         end
         MV_TO_REMOVED: begin
            move_ok = (p_x < rbeg_x);
            q_x     = rbeg_x - XW'(1);
         end
         default: begin
            move_ok = 1'b0;
            q_x     = '0;
         end
      endcase
   end

   assign plc_ra = head_idx;
   assign ord_ra = q_x[IW-1:0];

   // Sequence sweep, lookup, swap and result
   always_comb begin
      state_in     = state_ff;
      sweep_idx_in = sweep_idx_ff;
      for_item_in  = for_item_ff;
      kind_in      = kind_ff;
      side_in      = side_ff;
      u_in         = u_ff;
      sol_sel_in   = sol_sel_ff;
      fend_in      = fend_ff;
      rbeg_in      = rbeg_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      refused_in   = refused_ff;
      q_pop        = 1'b0;
      res_valid    = 1'b0;
      ord_we       = 2'b00;
      plc_we       = 2'b00;
      ord_wa       = '0;
      ord_wd       = '0;
      plc_wa       = '0;
      plc_wd       = '0;
      unique case (state_ff)
         BK_SWEEP: begin
            ord_we = 2'b11;
            plc_we = 2'b11;
            ord_wa = sweep_idx_ff;
            ord_wd = sweep_idx_ff;
            plc_wa = sweep_idx_ff;
            plc_wd = sweep_idx_ff;
            if (CW'(sweep_idx_ff) == eff_count - CW'(1)) begin
               refused_in = 1'b0;
               state_in   = for_item_ff ? BK_RESULT : BK_IDLE;
            end else begin
               sweep_idx_in = sweep_idx_ff + IW'(1);
            end
         end
         BK_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               kind_in    = q_item.kind;
               side_in    = q_item.side;
               u_in       = head_idx;
               sol_sel_in = sol_h;
               fend_in    = XW'(sol_h) + XW'(fre_h);
               rbeg_in    = eff_count - gone_h;
               refused_in = 1'b0;
               priority case (q_item.kind)
                  MV_CLEAR: begin
                     sweep_idx_in = '0;
                     for_item_in  = 1'b1;
                     state_in     = BK_SWEEP;
                  end
                  MV_REFUSE: begin
                     refused_in = 1'b1;
                     state_in   = BK_RESULT;
                  end
                  default: begin
                     state_in = BK_CHECK;
                  end
               endcase
            end
         end
         BK_CHECK: begin
            p_in = p_cur;
            q_in = q_x[IW-1:0];
            if (move_ok) begin
               state_in = BK_SWAP1;
            end else begin
               refused_in = 1'b1;
               state_in   = BK_RESULT;
            end
         end
         BK_SWAP1: begin
            // Displaced vertex takes the old slot
            ord_we   = side_ff ? 2'b10 : 2'b01;
            plc_we   = side_ff ? 2'b10 : 2'b01;
            ord_wa   = p_ff;
            ord_wd   = other;
            plc_wa   = other;
            plc_wd   = p_ff;
            state_in = BK_SWAP2;
         end
         BK_SWAP2: begin
            // Moved vertex takes the boundary slot
            ord_we   = side_ff ? 2'b10 : 2'b01;
            plc_we   = side_ff ? 2'b10 : 2'b01;
            ord_wa   = q_ff;
            ord_wd   = u_ff;
            plc_wa   = u_ff;
            plc_wd   = q_ff;
            state_in = BK_RESULT;
         end
         BK_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      // Restart the clearing pass on a count write
      if (clear_req) begin
         state_in     = BK_SWEEP;
         sweep_idx_in = '0;
         for_item_in  = 1'b0;
      end
   end

   // Update region counts
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         sol_in[s]  = sol_ff[s];
         fre_in[s]  = fre_ff[s];
         gone_in[s] = gone_ff[s];
         if (state_ff == BK_SWEEP) begin
            sol_in[s]  = '0;
            fre_in[s]  = eff_count;
            gone_in[s] = '0;
         end else if (state_ff == BK_SWAP2 && side_ff == 1'(s)) begin
            unique case (kind_ff)
               MV_FREE_TO_SOL: begin
                  sol_in[s] = sol_ff[s] + CW'(1);
                  fre_in[s] = fre_ff[s] - CW'(1);
               end
               MV_FREE_TO_NONFREE: fre_in[s] = fre_ff[s] - CW'(1);
               MV_SOL_TO_FREE: begin
                  sol_in[s] = sol_ff[s] - CW'(1);
                  fre_in[s] = fre_ff[s] + CW'(1);
               end
               MV_NONFREE_TO_FREE: fre_in[s] = fre_ff[s] + CW'(1);
               MV_TO_REMOVED:      gone_in[s] = gone_ff[s] + CW'(1);
               default: begin
                  sol_in[s] = sol_ff[s];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SWEEP;
         sweep_idx_ff <= '0;
         for_item_ff  <= 1'b0;
         refused_ff   <= 1'b0;
         for (int s = 0; s < 2; s++) begin
            sol_ff[s]  <= '0;
            fre_ff[s]  <= '0;
            gone_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sweep_idx_ff <= sweep_idx_in;
         for_item_ff  <= for_item_in;
         refused_ff   <= refused_in;
         for (int s = 0; s < 2; s++) begin
            sol_ff[s]  <= sol_in[s];
            fre_ff[s]  <= fre_in[s];
            gone_ff[s] <= gone_in[s];
         end
      end
   end

   // Hold the transaction under work
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      side_ff    <= side_in;
      u_ff       <= u_in;
      sol_sel_ff <= sol_sel_in;
      fend_ff    <= fend_in;
      rbeg_ff    <= rbeg_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
   end

   // Order tables
   always_ff @(posedge clock) begin
      if (ord_we[0]) begin
         order_a_mem[ord_wa] <= ord_wd;
      end
      if (ord_we[1]) begin
         order_b_mem[ord_wa] <= ord_wd;
      end
      ord_rd_a_ff <= order_a_mem[ord_ra];
      ord_rd_b_ff <= order_b_mem[ord_ra];
   end

   // Position tables
   always_ff @(posedge clock) begin
      if (plc_we[0]) begin
         place_a_mem[plc_wa] <= plc_wd;
      end
      if (plc_we[1]) begin
         place_b_mem[plc_wa] <= plc_wd;
      end
      plc_rd_a_ff <= place_a_mem[plc_ra];
      plc_rd_b_ff <= place_b_mem[plc_ra];
   end

   assign busy = (state_ff == BK_SWEEP);

   // Assemble the result
   assign res.refused          = refused_ff;
   assign res.solution_count_a = to_out(sol_ff[0]);
   assign res.solution_count_b = to_out(sol_ff[1]);
   assign res.free_count_a     = to_out(fre_ff[0]);
   assign res.free_count_b     = to_out(fre_ff[1]);
   assign res.removed_count_a  = to_out(gone_ff[0]);
   assign res.removed_count_b  = to_out(gone_ff[1]);
   assign res.maximal_a        = (fre_ff[0] == '0);
   assign res.maximal_b        = (fre_ff[1] == '0);
   assign res.sizes_equal      = (sol_ff[0] == sol_ff[1]);

   // Solution and free regions never run past the active count
   a_regions_fit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_IDLE |->
         (XW'(sol_ff[0]) + XW'(fre_ff[0]) <= XW'(eff_count)) &&
         (XW'(sol_ff[1]) + XW'(fre_ff[1]) <= XW'(eff_count)))
      else $error("solution and free regions exceed vertex count");

   // Removed region never exceeds the active count
   a_removed_fit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_IDLE |->
         (gone_ff[0] <= eff_count) && (gone_ff[1] <= eff_count))
      else $error("removed region exceeds vertex count");

   // Both swap slots lie inside the active range
   a_swap_slots: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SWAP2 |->
         (CW'(p_ff) < eff_count) && (CW'(q_ff) < eff_count))
      else $error("swap slot outside active range");

endmodule

// ===== rtl/core/partitioned_vertex_set.sv =====
// Partitioned vertex set: two sides, each a permutation of vertices with an
// inverse position table, split into solution, free, non-free and removed
// regions. Each req_ transaction moves one vertex between regions (or clears
// both sides) and returns one rsp_ transaction with the refused flag and the
// region counts, maximal flags and the sizes_equal flag after the request.
// The csr_ port writes vertex_count (saturated to 1..MAX_VERTICES) and clears
// both sides with the new count.
// Flow: a front decoder pushes requests into a two-entry
// queue; the back sequencer takes one at a time through place lookup, region
// check with order lookup, two table write steps and result handoff; the
// writes are split because each order and position table has one write port.
// A request refused for its code or vertex goes straight to the result
// handoff, one refused for its source region after the region check. A clear
// walks all active entries, one per cycle, then hands off its result.
// Reset and count writes start the same clearing pass; req_ready stays low
// while it runs. Results sit in an output register; while the
// receiver stalls, up to two more requests are accepted into the queue.
module partitioned_vertex_set #(
   parameter int unsigned MAX_VERTICES = pvs_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [pvs_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pvs_pkg::FUNC_W-1:0]       req_func,
   input  logic                             req_side,
   input  logic [pvs_pkg::VERTEX_W-1:0]     req_vertex,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_refused,
   output logic [pvs_pkg::COUNT_W-1:0]      rsp_solution_count_a,
   output logic [pvs_pkg::COUNT_W-1:0]      rsp_solution_count_b,
   output logic [pvs_pkg::COUNT_W-1:0]      rsp_free_count_a,
   output logic [pvs_pkg::COUNT_W-1:0]      rsp_free_count_b,
   output logic [pvs_pkg::COUNT_W-1:0]      rsp_removed_count_a,
   output logic [pvs_pkg::COUNT_W-1:0]      rsp_removed_count_b,
   output logic                             rsp_maximal_a,
   output logic                             rsp_maximal_b,
   output logic                             rsp_sizes_equal
);
   import pvs_pkg::*;

   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned VW = (CW > CSR_W) ? CW : CSR_W;

   logic [CSR_W-1:0] vcount_ff, vcount_in;
   logic [VW-1:0]    vc_wide, eff_wide;
   logic [CW-1:0]    eff_count;

   logic       busy, q_full, q_not_empty, q_pop, push;
   item_type   push_item, q_head;
   logic       res_valid, res_ready;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // Vertex count register
   assign vcount_in = csr_wen ? csr_wdata : vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   // Saturate the count to 1..MAX_VERTICES
   always_comb begin
      vc_wide = VW'(vcount_ff);
      priority if (vcount_ff == '0) begin
         eff_wide = VW'(1);
      end else if (vc_wide > VW'(MAX_VERTICES)) begin
         eff_wide = VW'(MAX_VERTICES);
      end else begin
         eff_wide = vc_wide;
      end
   end
   assign eff_count = eff_wide[CW-1:0];

   pvs_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_side   (req_side),
      .req_vertex (req_vertex),
      .eff_count  (eff_count),
      .busy       (busy),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   pvs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   pvs_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .clear_req (csr_wen),
      .eff_count (eff_count),
      .q_valid   (q_not_empty),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .busy      (busy),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // Output register
   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_refused          = rsp_ff.refused;
   assign rsp_solution_count_a = rsp_ff.solution_count_a;
   assign rsp_solution_count_b = rsp_ff.solution_count_b;
   assign rsp_free_count_a     = rsp_ff.free_count_a;
   assign rsp_free_count_b     = rsp_ff.free_count_b;
   assign rsp_removed_count_a  = rsp_ff.removed_count_a;
   assign rsp_removed_count_b  = rsp_ff.removed_count_b;
   assign rsp_maximal_a        = rsp_ff.maximal_a;
   assign rsp_maximal_b        = rsp_ff.maximal_b;
   assign rsp_sizes_equal      = rsp_ff.sizes_equal;

endmodule
